// ===== hdl/tes_pkg.sv =====
// Shared types and codes for the timed event sequencer.
package tes_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    localparam logic [2:0] KIND_OPEN        = 3'd0;
    localparam logic [2:0] KIND_CLOSE       = 3'd1;
    localparam logic [2:0] KIND_SPEED       = 3'd2;
    localparam logic [2:0] KIND_SPEED_OPEN  = 3'd3;
    localparam logic [2:0] KIND_SPEED_CLOSE = 3'd4;

    typedef struct packed {
        logic [31:0] tstamp;
        logic [2:0]  kind;
        logic [15:0] speed;
    } t_entry;

    typedef struct packed {
        logic load;
        logic start_step;
        logic read_next;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== hdl/timed_event_sequencer.sv =====
// Top level of the timed event sequencer.
//
// Input channel (i_in_valid / o_in_ready) carries one beat per item: a load
// (i_op = 0) appends an event to the table, i_load_first first empties the
// table and rewinds the step pointer; a step (i_op = 1) plays the event under
// the step pointer. Output channel (o_out_valid / i_out_ready) returns one
// result beat per item.
// A load answers on the cycle after acceptance. A step reads the entry under
// the pointer, then the following entry, then fills the result stage.
// Throughput: one load per cycle while results are taken; no new item is
// taken until a step's result is registered (two sequential memory reads).
// A load is taken only when the result register is free or drains in the
// same cycle; a step is taken anyway and holds in its last stage until the
// result register frees up, so a stalled receiver stops the input side.
// Reset clears the event count, the step pointer and the output valid; the
// event memory keeps whatever it held; reads past the event count go unused.
module timed_event_sequencer
    import tes_pkg::*;
#(
    parameter int MAX_EVENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic        i_load_first,
    input  logic [31:0] i_event_time_ms,
    input  logic [2:0]  i_event_kind,
    input  logic [15:0] i_event_speed,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic        o_go_home,
    output logic        o_valve_open,
    output logic        o_valve_close,
    output logic        o_speed_valid,
    output logic [15:0] o_speed_value,
    output logic [31:0] o_wait_ms
);

    t_dp_cmd    cmd;
    t_dp_status st;

    tes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_st       (st),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    tes_dp #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_load_first    (i_load_first),
        .i_event_time_ms (i_event_time_ms),
        .i_event_kind    (i_event_kind),
        .i_event_speed   (i_event_speed),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_go_home       (o_go_home),
        .o_valve_open    (o_valve_open),
        .o_valve_close   (o_valve_close),
        .o_speed_valid   (o_speed_valid),
        .o_speed_value   (o_speed_value),
        .o_wait_ms       (o_wait_ms)
    );

endmodule

// ===== hdl/tes_ctrl.sv =====
// Controller state machine for the timed event sequencer.
module tes_ctrl
    import tes_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_op,
    input  t_dp_status i_st,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ_NEXT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // A load answers at once, so it needs the output slot free now.
    always_comb begin
        o_in_ready = (r_state == S_IDLE) && ((i_op == OP_STEP) || i_st.out_free);
        accept     = i_in_valid && o_in_ready;

        o_cmd.load       = accept && (i_op == OP_LOAD);
        o_cmd.start_step = accept && (i_op == OP_STEP);
        o_cmd.read_next  = (r_state == S_READ_NEXT);
        o_cmd.finish     = (r_state == S_FINISH) && i_st.out_free;

        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.start_step) n_state = S_READ_NEXT;
            end
            S_READ_NEXT: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/tes_dp.sv =====
// Datapath of the timed event sequencer: event memory, pointers, result register.
module tes_dp
    import tes_pkg::*;
#(
    parameter int MAX_EVENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_st,
    input  logic        i_load_first,
    input  logic [31:0] i_event_time_ms,
    input  logic [2:0]  i_event_kind,
    input  logic [15:0] i_event_speed,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic        o_go_home,
    output logic        o_valve_open,
    output logic        o_valve_close,
    output logic        o_speed_valid,
    output logic [15:0] o_speed_value,
    output logic [31:0] o_wait_ms
);

    localparam int IW = $clog2(MAX_EVENTS);
    localparam int CW = $clog2(MAX_EVENTS + 1);

    t_entry          mem [MAX_EVENTS];
    t_entry          r_rd;
    t_entry          r_e0;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_step;
    logic [IW-1:0]   r_s;
    logic            r_home;
    logic            r_empty;
    logic            r_out_valid;

    logic            fits;
    logic [IW-1:0]   wr_idx;
    logic            wrap;
    logic            empty;
    logic [IW-1:0]   s_start;
    logic [IW-1:0]   rd_addr;
    logic [CW-1:0]   s_plus1;
    logic            ok;
    logic            vopen;
    logic            vclose;
    logic            svalid;

    assign o_st.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;

    always_comb begin
        fits    = i_load_first || (r_count < CW'(MAX_EVENTS));
        wr_idx  = i_load_first ? '0 : r_count[IW-1:0];
        empty   = (r_count == '0);
        wrap    = (r_step >= r_count);
        s_start = wrap ? '0 : r_step[IW-1:0];
        s_plus1 = CW'(r_s) + CW'(1);
        // Second read fetches the following entry for the time difference.
        rd_addr = i_cmd.read_next ? IW'(s_plus1) : s_start;

        ok     = 1'b1;
        vopen  = 1'b0;
        vclose = 1'b0;
        svalid = 1'b0;
        unique case (r_e0.kind)
            KIND_OPEN:        vopen = 1'b1;
            KIND_CLOSE:       vclose = 1'b1;
            KIND_SPEED:       svalid = 1'b1;
            KIND_SPEED_OPEN:  begin svalid = 1'b1; vopen = 1'b1; end
            KIND_SPEED_CLOSE: begin svalid = 1'b1; vclose = 1'b1; end
            default:          ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && fits) begin
            mem[wr_idx] <= '{tstamp: i_event_time_ms, kind: i_event_kind,
                             speed: i_event_speed};
        end
        // Hold the following entry while the result waits for the receiver.
        if (i_cmd.start_step || i_cmd.read_next) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Step context and result payload: no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_step) begin
            r_s     <= s_start;
            r_home  <= wrap && !empty;
            r_empty <= empty;
        end
        if (i_cmd.read_next) begin
            r_e0 <= r_rd;
        end
        if (i_cmd.load) begin
            o_status      <= !fits;
            o_go_home     <= 1'b0;
            o_valve_open  <= 1'b0;
            o_valve_close <= 1'b0;
            o_speed_valid <= 1'b0;
            o_speed_value <= '0;
            o_wait_ms     <= '0;
        end else if (i_cmd.finish) begin
            if (r_empty) begin
                o_status      <= 1'b1;
                o_go_home     <= 1'b0;
                o_valve_open  <= 1'b0;
                o_valve_close <= 1'b0;
                o_speed_valid <= 1'b0;
                o_speed_value <= '0;
                o_wait_ms     <= '0;
            end else begin
                o_status      <= !ok;
                o_go_home     <= r_home;
                o_valve_open  <= vopen;
                o_valve_close <= vclose;
                o_speed_valid <= svalid;
                o_speed_value <= svalid ? r_e0.speed : '0;
                o_wait_ms     <= (ok && (s_plus1 < r_count)) ?
                                 (r_rd.tstamp - r_e0.tstamp) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                if (i_load_first) begin
                    r_count <= CW'(1);
                    r_step  <= '0;
                end else if (fits) begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.finish && !r_empty) begin
                // Hold the pointer on a bad kind; a wrap stays done.
                r_step <= ok ? s_plus1 : CW'(r_s);
            end
            if (i_cmd.load || i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/tes_chk.sv =====
// Port-level checks for the timed event sequencer, bound to the top level.
module tes_chk
    import tes_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_op,
    input logic        i_load_first,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_status,
    input logic        o_go_home,
    input logic        o_valve_open,
    input logic        o_valve_close,
    input logic        o_speed_valid,
    input logic [15:0] o_speed_value,
    input logic [31:0] o_wait_ms
);

    // Stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_wait_ms)
            && $stable(o_speed_value))
        else $error("result beat changed while stalled");

    // A fresh table always has room.
    a_first_load_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_LOAD) && i_load_first |=>
            o_out_valid && !o_status && !o_go_home)
        else $error("first load did not answer ok");

    // A step keeps the input side busy while it reads the table.
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_op == OP_STEP) |=> !o_in_ready)
        else $error("input taken during a step");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |->
            !o_valve_open && !o_valve_close && !o_speed_valid && (o_wait_ms == '0))
        else $error("error result carries a command");

    a_speed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_speed_valid |-> (o_speed_value == '0))
        else $error("speed value without speed valid");

endmodule

bind timed_event_sequencer tes_chk u_tes_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_op          (i_op),
    .i_load_first  (i_load_first),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_go_home     (o_go_home),
    .o_valve_open  (o_valve_open),
    .o_valve_close (o_valve_close),
    .o_speed_valid (o_speed_valid),
    .o_speed_value (o_speed_value),
    .o_wait_ms     (o_wait_ms)
);
